### rtl/indexed_priority_table_assert.svh
// Assertion macros shared by the indexed priority table RTL.
// No dependencies; files that assert take this header in by include.
`ifndef INDEXED_PRIORITY_TABLE_ASSERT_SVH
`define INDEXED_PRIORITY_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define IPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("indexed_priority_table: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define IPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("indexed_priority_table: next-cycle check failed");
// Invariant, checked outside reset.
`define IPT_ASSERT_ALW(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("indexed_priority_table: invariant failed");
`else
`define IPT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IPT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`define IPT_ASSERT_ALW(label, clk, rst_n, cond)
`endif

`endif

### rtl/ipt_pkg.sv
// Package for the indexed priority table: field widths, defaults, opcodes,
// and the RAM control struct. No dependencies.
package ipt_pkg;

	// Fixed field widths of the request and response channels
	localparam int OPCODE_W   = 2;
	localparam int SLOT_ID_W  = 8;
	localparam int AMOUNT_W   = 16;
	localparam int LEVEL_O_W  = 16;
	localparam int SLOT_SPACE = 2 ** SLOT_ID_W;

	// Parameter defaults
	localparam int SLOTS_DEF      = 256;
	localparam int LEVEL_BITS_DEF = 16;
	localparam int STAMP_BITS_DEF = 32;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd3;

	// RAM port controls
	typedef struct packed {
		logic wr;
		logic rd;
	} ram_ctl_t;

endpackage

### rtl/ipt_ram.sv
// Generic single-port RAM with registered read data.
// Depends on ipt_pkg for the control struct.
module ipt_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  ipt_pkg::ram_ctl_t        ctl,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	import ipt_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/indexed_priority_table.sv
// Indexed priority table, top level: sequencer, occupancy bits, shared
// saturating adder and scan comparator. Depends on ipt_pkg, ipt_ram and
// indexed_priority_table_assert.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  request | req_valid / req_stall | opcode, slot_id, amount
//  result  | rsp_valid / rsp_stall | found, best_slot, best_level
//
// Sequence: insert and remove act as the request is accepted; add reads the RAM,
//   then writes back through the saturating adder. A query reads one slot at a
//   time through the single port, compares the last entry in ST_DRAIN, then
//   loads the result register. USED = min(SLOTS, 256).
// Reset: clears occupancy, the arrival counter and all handshake state; the
//   level/stamp RAM is left as is and used only for occupied slots.
// Stalls: req_stall is high while an item is in work. A result waits in its
//   register; a later query holds in its final state until that register frees.
`include "indexed_priority_table_assert.svh"

module indexed_priority_table #(
	parameter int SLOTS      = ipt_pkg::SLOTS_DEF,
	parameter int LEVEL_BITS = ipt_pkg::LEVEL_BITS_DEF,
	parameter int STAMP_BITS = ipt_pkg::STAMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [ipt_pkg::OPCODE_W-1:0]  opcode,
	input  logic [ipt_pkg::SLOT_ID_W-1:0] slot_id,
	input  logic [ipt_pkg::AMOUNT_W-1:0]  amount,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          found,
	output logic [ipt_pkg::SLOT_ID_W-1:0] best_slot,
	output logic [ipt_pkg::LEVEL_O_W-1:0] best_level
);
	import ipt_pkg::*;

	// Only slots that slot_id can reach are built
	localparam int USED   = (SLOTS < SLOT_SPACE) ? SLOTS : SLOT_SPACE;
	localparam int IDX_W  = $clog2(USED);
	localparam int WORD_W = LEVEL_BITS + STAMP_BITS;
	localparam int SUM_W  = ((LEVEL_BITS > AMOUNT_W) ? LEVEL_BITS : AMOUNT_W) + 1;

	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
	localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
	localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(USED - 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ADD    = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0]            state_q;
	logic [USED-1:0]       occ_q;
	logic [STAMP_BITS-1:0] arrival_q;
	logic [IDX_W-1:0]      slot_q;
	logic [AMOUNT_W-1:0]   amount_q;
	logic [IDX_W-1:0]      scan_idx_q;

	// Compare stage, aligned with the registered RAM read
	logic             vld_s1;
	logic             occ_s1;
	logic [IDX_W-1:0] idx_s1;

	// Running best of the scan
	logic                  any_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [LEVEL_BITS-1:0] best_lvl_q;
	logic [STAMP_BITS-1:0] best_stmp_q;

	// Result register
	logic                 rsp_valid_q;
	logic                 found_q;
	logic [SLOT_ID_W-1:0] best_slot_q;
	logic [LEVEL_O_W-1:0] best_level_q;

	logic                  req_xfer;
	logic                  in_range;
	logic [IDX_W-1:0]      slot_idx;
	logic                  slot_occ;
	logic [STAMP_BITS-1:0] next_stamp;
	logic                  do_insert;
	logic                  do_add;
	logic                  do_remove;
	logic                  rsp_free;
	logic                  take;
	logic                  scan_last;
	logic                  rsp_zero;

	ram_ctl_t              ram_ctl;
	logic [IDX_W-1:0]      ram_addr;
	logic [WORD_W-1:0]     ram_wdata;
	logic [WORD_W-1:0]     ram_rdata;
	logic [LEVEL_BITS-1:0] rd_level;
	logic [STAMP_BITS-1:0] rd_stamp;

	// Shared saturating adder
	logic [LEVEL_BITS-1:0] add_base;
	logic [AMOUNT_W-1:0]   add_inc;
	logic [SUM_W-1:0]      add_sum;
	logic [LEVEL_BITS-1:0] add_sat;

	assign req_stall = (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign in_range  = (32'(slot_id) < 32'(USED));
	assign slot_idx  = slot_id[IDX_W-1:0];
	assign slot_occ  = in_range && occ_q[slot_idx];

	// Ignore an insert into an occupied slot and add/remove on an empty one
	assign do_insert = req_xfer && (opcode == OP_INSERT) && in_range && !slot_occ;
	assign do_add    = req_xfer && (opcode == OP_ADD) && slot_occ;
	assign do_remove = req_xfer && (opcode == OP_REMOVE) && slot_occ;

	// Saturating arrival counter; the new count stamps the insert
	assign next_stamp = (arrival_q == STAMP_MAX) ? arrival_q : arrival_q + STAMP_BITS'(1);

	assign rd_level = ram_rdata[WORD_W-1:STAMP_BITS];
	assign rd_stamp = ram_rdata[STAMP_BITS-1:0];

	// Insert adds the amount to zero, add to the stored level
	assign add_base = (state_q == ST_ADD) ? rd_level : '0;
	assign add_inc  = (state_q == ST_ADD) ? amount_q : amount;
	assign add_sum  = SUM_W'(add_base) + SUM_W'(add_inc);
	assign add_sat  = (add_sum > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : add_sum[LEVEL_BITS-1:0];

	// RAM port: one read or one write per cycle
	always_comb begin
		ram_ctl   = '0;
		ram_addr  = slot_idx;
		ram_wdata = {add_sat, next_stamp};
		unique case (state_q)
			ST_IDLE: begin
				ram_ctl.wr = do_insert;
				ram_ctl.rd = do_add;
			end
			ST_ADD: begin
				ram_ctl.wr = 1'b1;
				ram_addr   = slot_q;
				ram_wdata  = {add_sat, rd_stamp};
			end
			ST_SCAN: begin
				ram_ctl.rd = 1'b1;
				ram_addr   = scan_idx_q;
			end
			default: begin
			end
		endcase
	end

	ipt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(USED)
	) u_ram (
		.clk  (clk),
		.ctl  (ram_ctl),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Replace the best on a higher level, or an equal level with an earlier
	// stamp; a full tie keeps the lower slot seen first
	assign take = vld_s1 && occ_s1 &&
		(!any_q || (rd_level > best_lvl_q) ||
		 ((rd_level == best_lvl_q) && (rd_stamp < best_stmp_q)));

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			arrival_q   <= '0;
			scan_idx_q  <= '0;
			vld_s1      <= 1'b0;
			any_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			// Drop valid after a transfer unless a new result loads this cycle
			if ((state_q != ST_RESULT) && rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (take) begin
				any_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_insert) begin
						occ_q[slot_idx] <= 1'b1;
						arrival_q       <= next_stamp;
					end
					if (do_remove) begin
						occ_q[slot_idx] <= 1'b0;
					end
					if (do_add) begin
						state_q <= ST_ADD;
					end
					if (req_xfer && (opcode == OP_QUERY)) begin
						state_q    <= ST_SCAN;
						scan_idx_q <= '0;
						any_q      <= 1'b0;
					end
				end
				ST_ADD: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					// Advance one slot per cycle; the last read drains next
					if (scan_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					// Hold until the result register is free
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (do_add) begin
			slot_q   <= slot_idx;
			amount_q <= amount;
		end
		occ_s1 <= occ_q[scan_idx_q];
		idx_s1 <= scan_idx_q;
		if (take) begin
			best_idx_q  <= idx_s1;
			best_lvl_q  <= rd_level;
			best_stmp_q <= rd_stamp;
		end
		if ((state_q == ST_RESULT) && rsp_free) begin
			found_q      <= any_q;
			best_slot_q  <= any_q ? SLOT_ID_W'(best_idx_q) : '0;
			best_level_q <= any_q ? LEVEL_O_W'(best_lvl_q) : '0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign found      = found_q;
	assign best_slot  = best_slot_q;
	assign best_level = best_level_q;

	assign scan_last = (state_q == ST_SCAN) && (scan_idx_q == LAST_IDX);
	assign rsp_zero  = (best_slot == '0) && (best_level == '0);

	`IPT_ASSERT_ALW(a_port_exclusive, clk, arst_n, !(ram_ctl.wr && ram_ctl.rd))
	`IPT_ASSERT_IMP(a_add_after_xfer, clk, arst_n, state_q == ST_ADD, $past(do_add))
	`IPT_ASSERT_IMP(a_rsp_from_result, clk, arst_n, $rose(rsp_valid), $past(state_q) == ST_RESULT)
	`IPT_ASSERT_IMP(a_empty_is_zero, clk, arst_n, rsp_valid && !found, rsp_zero)
	`IPT_ASSERT_NXT(a_scan_ends, clk, arst_n, scan_last, state_q == ST_DRAIN)

endmodule

### bench/indexed_priority_table_tb.sv
// Self-checking bench for indexed_priority_table: a burst driver, a stalling
// monitor and a scan predictor for query answers. Depends on ipt_pkg and the RTL.
module indexed_priority_table_tb;
	import ipt_pkg::*;

	localparam int LVL_W       = LEVEL_BITS_DEF;
	localparam int STAMP_W     = STAMP_BITS_DEF;
	localparam int RANDOM_OPS  = 1450;
	localparam int SETTLE_CYC  = 400;   // a full scan plus the result register
	localparam int DRAIN_LIMIT = 20000;

	typedef struct {
		logic [OPCODE_W-1:0]  op;
		logic [SLOT_ID_W-1:0] id;
		logic [AMOUNT_W-1:0]  amt;
	} request_t;

	typedef struct {
		logic                 found;
		logic [SLOT_ID_W-1:0] slot;
		logic [LEVEL_O_W-1:0] level;
	} top_answer_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 req_valid  = 1'b0;
	logic                 req_stall;
	logic [OPCODE_W-1:0]  opcode     = OP_INSERT;
	logic [SLOT_ID_W-1:0] slot_id    = '0;
	logic [AMOUNT_W-1:0]  amount     = '0;
	logic                 rsp_valid;
	logic                 rsp_stall  = 1'b0;
	logic                 found;
	logic [SLOT_ID_W-1:0] best_slot;
	logic [LEVEL_O_W-1:0] best_level;

	// Stimulus waiting to be offered, and query answers waiting to come back
	request_t    request_queue [$];
	top_answer_t top_answers [$];

	// Predicted table contents
	bit                 occ_bits  [SLOT_SPACE];
	logic [LVL_W-1:0]   lvl_mem   [SLOT_SPACE];
	logic [STAMP_W-1:0] stamp_mem [SLOT_SPACE];
	logic [STAMP_W-1:0] arrival_ctr = '0;

	// Occupancy as seen by the generator, to steer stimulus toward live slots
	bit gen_occ [SLOT_SPACE];

	int fail_count   = 0;
	int answers_seen = 0;

	indexed_priority_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.opcode     (opcode),
		.slot_id    (slot_id),
		.amount     (amount),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.found      (found),
		.best_slot  (best_slot),
		.best_level (best_level)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one accepted request to the predicted table; a query pushes the
	// answer the block must give: highest level, then earliest stamp, then
	// lowest slot (strict compares keep the lower slot on a full tie).
	task automatic apply_request(input request_t rq);
		top_answer_t ans;
		logic [LVL_W:0] sum;
		ans = '{found: 1'b0, slot: '0, level: '0};
		case (rq.op)
			OP_QUERY: begin
				for (int k = 0; k < SLOT_SPACE; k++) begin
					if (occ_bits[k] && (!ans.found || lvl_mem[k] > ans.level ||
							(lvl_mem[k] == ans.level && stamp_mem[k] < stamp_mem[ans.slot]))) begin
						ans.found = 1'b1;
						ans.slot  = k[SLOT_ID_W-1:0];
						ans.level = lvl_mem[k];
					end
				end
				top_answers.push_back(ans);
			end
			OP_INSERT: begin
				// An insert into a live slot leaves even the counter alone
				if (!occ_bits[rq.id]) begin
					if (arrival_ctr != '1)
						arrival_ctr = arrival_ctr + 1'b1;
					occ_bits[rq.id]  = 1'b1;
					lvl_mem[rq.id]   = rq.amt;
					stamp_mem[rq.id] = arrival_ctr;
				end
			end
			OP_ADD: begin
				if (occ_bits[rq.id]) begin
					sum = {1'b0, lvl_mem[rq.id]} + rq.amt;
					lvl_mem[rq.id] = sum[LVL_W] ? '1 : sum[LVL_W-1:0];
				end
			end
			OP_REMOVE: begin
				occ_bits[rq.id] = 1'b0;
			end
		endcase
	endtask

	// Queue a request; report whether it changes the table or is a query
	function automatic bit queue_request(input logic [OPCODE_W-1:0] op,
			input logic [SLOT_ID_W-1:0] id, input logic [AMOUNT_W-1:0] amt);
		bit live;
		live = gen_occ[id];
		request_queue.push_back('{op: op, id: id, amt: amt});
		case (op)
			OP_INSERT: gen_occ[id] = 1'b1;
			OP_REMOVE: gen_occ[id] = 1'b0;
			default: ;
		endcase
		if (op == OP_QUERY)
			return 1'b1;
		return (op == OP_INSERT) ? !live : live;
	endfunction

	// Favor a small cluster of slots so inserts, adds and removes collide
	function automatic logic [SLOT_ID_W-1:0] pick_slot();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return SLOT_ID_W'($urandom_range(0, 15));
		if (r < 65)
			return $urandom_range(0, 1) ? '1 : '0;
		return SLOT_ID_W'($urandom_range(0, SLOT_SPACE - 1));
	endfunction

	function automatic logic [SLOT_ID_W-1:0] pick_slot_where(input bit want_live);
		logic [SLOT_ID_W-1:0] id;
		for (int t = 0; t < 8; t++) begin
			id = pick_slot();
			if (gen_occ[id] == want_live)
				return id;
		end
		return id;
	endfunction

	// Small values make level ties, values near the top hit saturation
	function automatic logic [AMOUNT_W-1:0] pick_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return AMOUNT_W'($urandom_range(0, 7));
		if (r < 50)
			return AMOUNT_W'($urandom_range(2 ** AMOUNT_W - 8, 2 ** AMOUNT_W - 1));
		if (r < 60)
			return $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
		return AMOUNT_W'($urandom_range(0, 2 ** AMOUNT_W - 1));
	endfunction

	// Driver: offer queued requests in bursts, hold the payload while stalled,
	// and feed every accepted transfer to the predictor.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		request_t nxt;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			req_valid  <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (req_valid && !req_stall)
				apply_request('{op: opcode, id: slot_id, amt: amount});
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					// Idle: drop valid and scramble the payload lines
					gap_left  = gap_left - 1;
					req_valid <= 1'b0;
					opcode    <= OPCODE_W'($urandom);
					slot_id   <= SLOT_ID_W'($urandom);
					amount    <= AMOUNT_W'($urandom);
				end else if (request_queue.size() > 0) begin
					nxt = request_queue.pop_front();
					req_valid <= 1'b1;
					opcode    <= nxt.op;
					slot_id   <= nxt.id;
					amount    <= nxt.amt;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left = burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest expected answer,
	// and stall on a pattern of moods, with one long hold-off to back up the block.
	always @(posedge clk or negedge arst_n) begin : watch_answers
		top_answer_t want;
		int mood;
		int mood_left;
		int hold_left;
		bit hold_done;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			mood      = 0;
			mood_left = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				answers_seen = answers_seen + 1;
				if (top_answers.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("unexpected answer: found=%0d slot=%0d level=%0d",
							found, best_slot, best_level);
				end else begin
					want = top_answers.pop_front();
					if (found !== want.found || best_slot !== want.slot ||
							best_level !== want.level) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10)
							$display("mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
								want.found, want.slot, want.level,
								found, best_slot, best_level);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				rsp_stall <= 1'b1;
			end else if (!hold_done && answers_seen >= 40) begin
				// Hold off long enough that a query finishes and the next one backs up
				hold_done = 1'b1;
				hold_left = 3000;
				rsp_stall <= 1'b1;
			end else begin
				if (mood_left == 0) begin
					mood      = $urandom_range(0, 3);
					mood_left = $urandom_range(20, 400);
				end else begin
					mood_left = mood_left - 1;
				end
				case (mood)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 2) == 0);
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= mood_left[2];
				endcase
			end
		end
	end

	initial begin : run_test
		int effective;
		int r;
		int waited;

		// Directed: empty query, level extremes, saturation, ignored operations,
		// an empty table again, then a stamp tie-break on equal levels.
		void'(queue_request(OP_QUERY,  8'd255, 16'hFFFF));
		void'(queue_request(OP_INSERT, 8'd0,   16'h0000));
		void'(queue_request(OP_INSERT, 8'd255, 16'hFFFF));
		void'(queue_request(OP_QUERY,  8'd0,   16'h0000));
		void'(queue_request(OP_ADD,    8'd255, 16'h0001));
		void'(queue_request(OP_ADD,    8'd255, 16'hFFFF));
		void'(queue_request(OP_INSERT, 8'd200, 16'hFFFF));
		void'(queue_request(OP_QUERY,  8'd170, 16'h5555));
		void'(queue_request(OP_INSERT, 8'd255, 16'h0005));
		void'(queue_request(OP_REMOVE, 8'd255, 16'hAAAA));
		void'(queue_request(OP_QUERY,  8'd85,  16'hAAAA));
		void'(queue_request(OP_ADD,    8'd7,   16'd100));
		void'(queue_request(OP_REMOVE, 8'd7,   16'h0000));
		void'(queue_request(OP_ADD,    8'd0,   16'hFFFF));
		void'(queue_request(OP_QUERY,  8'd0,   16'h0000));
		void'(queue_request(OP_INSERT, 8'd128, 16'hFFFE));
		void'(queue_request(OP_ADD,    8'd128, 16'h0001));
		void'(queue_request(OP_QUERY,  8'd1,   16'h0001));
		void'(queue_request(OP_REMOVE, 8'd0,   16'h0000));
		void'(queue_request(OP_REMOVE, 8'd200, 16'h0000));
		void'(queue_request(OP_QUERY,  8'd0,   16'h0000));
		void'(queue_request(OP_REMOVE, 8'd128, 16'h0000));
		void'(queue_request(OP_QUERY,  8'd0,   16'h0000));
		void'(queue_request(OP_INSERT, 8'd1,   16'h8000));
		void'(queue_request(OP_INSERT, 8'd2,   16'h8000));
		void'(queue_request(OP_QUERY,  8'd0,   16'h0000));

		// Random: mostly well-formed operations on live or free slots, some noise,
		// and now and then a full drain followed by a query of the empty table.
		effective = 0;
		while (effective < RANDOM_OPS) begin
			if ($urandom_range(0, 999) < 4) begin
				for (int k = 0; k < SLOT_SPACE; k++)
					if (gen_occ[k])
						effective += queue_request(OP_REMOVE, k[SLOT_ID_W-1:0],
							AMOUNT_W'($urandom));
				effective += queue_request(OP_QUERY, SLOT_ID_W'($urandom),
					AMOUNT_W'($urandom));
			end
			r = $urandom_range(0, 99);
			if (r < 30)
				effective += queue_request(OP_INSERT, pick_slot_where(1'b0), pick_amount());
			else if (r < 55)
				effective += queue_request(OP_ADD, pick_slot_where(1'b1), pick_amount());
			else if (r < 70)
				effective += queue_request(OP_REMOVE, pick_slot_where(1'b1),
					AMOUNT_W'($urandom));
			else if (r < 88)
				effective += queue_request(OP_QUERY, SLOT_ID_W'($urandom),
					AMOUNT_W'($urandom));
			else
				effective += queue_request(OPCODE_W'($urandom), SLOT_ID_W'($urandom),
					AMOUNT_W'($urandom));
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Wait until every request is taken, then for the answers to drain
		while (request_queue.size() != 0 || req_valid)
			@(posedge clk);
		waited = 0;
		while (top_answers.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		fail_count += top_answers.size();
		repeat (SETTLE_CYC) @(posedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#40000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
